// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/imhq_pkg.sv
package imhq_pkg;

    localparam int unsigned Capacity    = 256;
    localparam int unsigned PayloadBits = 32;
    localparam int unsigned AddrW       = $clog2(Capacity);
    localparam int unsigned CountW      = $clog2(Capacity + 1);

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_POP = 2'd1;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPGRADED  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_POPPED    = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_FOUND     = 3'd6;
    localparam logic [2:0] ST_ABSENT    = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [7:0]  priority_req;
        logic [31:0] payload;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_key;
        logic [7:0]  out_priority;
        logic [31:0] out_payload;
        logic [8:0]  entry_count;
    } t_out_word;

    // one heap slot
    typedef struct packed {
        logic [63:0]            key;
        logic [7:0]             prio;
        logic [PayloadBits-1:0] pay;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,   // issue read of search address
        S_SRCH_CMP,  // compare read key
        S_UP_RD,     // read parent
        S_UP_CMP,    // compare with parent, swap
        S_POP_RD,    // last-slot data back, becomes moving entry
        S_DN_RDL,    // read left child
        S_DN_RDR,    // read right child, left data back
        S_DN_CMP,    // pick best child, swap
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;
        logic rd_srch;
        logic srch_next;
        logic set_cur_hit;
        logic do_append;
        logic do_upgrade;
        logic rd_parent;
        logic swap_up;
        logic rd_last;
        logic pop_root;
        logic rd_left;
        logic rd_right;
        logic latch_left;
        logic swap_down;
        logic emit;
        logic [2:0] status;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic srch_end;
        logic key_hit;
        logic prio_higher;
        logic full;
        logic empty;
        logic at_root;
        logic up_move;
        logic has_left;
        logic has_right;
        logic dn_move;
        logic pop_last;
    } t_sts;

endpackage

// File: rtl/core/imhq_ctrl.sv
module imhq_ctrl import imhq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_sts   i_sts,
    output logic   o_busy,
    output t_cmd   o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SRCH_RD;
            end
            S_SRCH_RD: begin
                if (i_sts.opcode == OP_POP) begin
                    if (i_sts.empty)     n_state = S_DONE;
                    else if (i_sts.pop_last) n_state = S_DONE;
                    else                 n_state = S_POP_RD;
                end else if (i_sts.srch_end) begin
                    if (i_sts.opcode == OP_ENQ && !i_sts.full) n_state = S_UP_RD;
                    else                                       n_state = S_DONE;
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (!i_sts.key_hit) n_state = S_SRCH_RD;
                else if (i_sts.opcode == OP_ENQ && i_sts.prio_higher) n_state = S_UP_RD;
                else n_state = S_DONE;
            end
            S_UP_RD:  n_state = i_sts.at_root ? S_DONE : S_UP_CMP;
            S_UP_CMP: n_state = i_sts.up_move ? S_UP_RD : S_DONE;
            S_POP_RD: n_state = S_DN_RDL;
            S_DN_RDL: n_state = i_sts.has_left ? S_DN_RDR : S_DONE;
            S_DN_RDR: n_state = S_DN_CMP;
            S_DN_CMP: n_state = i_sts.dn_move ? S_DN_RDL : S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    logic [2:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // commands
    always_comb begin
        o_cmd    = '0;
        n_status = r_status;
        o_busy   = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = i_start;
            end
            S_SRCH_RD: begin
                if (i_sts.opcode == OP_POP) begin
                    if (i_sts.empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status       = ST_POPPED;
                        o_cmd.pop_root = 1'b1;
                        o_cmd.rd_last  = !i_sts.pop_last;
                    end
                end else if (i_sts.srch_end) begin
                    if (i_sts.opcode != OP_ENQ) begin
                        n_status = ST_ABSENT;
                    end else if (i_sts.full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status        = ST_INSERTED;
                        o_cmd.do_append = 1'b1;
                    end
                end else begin
                    o_cmd.rd_srch = 1'b1;
                end
            end
            S_SRCH_CMP: begin
                if (!i_sts.key_hit) begin
                    o_cmd.srch_next = 1'b1;
                end else if (i_sts.opcode != OP_ENQ) begin
                    n_status = ST_FOUND;
                end else if (i_sts.prio_higher) begin
                    n_status         = ST_UPGRADED;
                    o_cmd.set_cur_hit = 1'b1;
                    o_cmd.do_upgrade = 1'b1;
                end else begin
                    n_status = ST_DUPLICATE;
                end
            end
            S_UP_RD:  o_cmd.rd_parent  = !i_sts.at_root;
            S_UP_CMP: o_cmd.swap_up    = i_sts.up_move;
            S_DN_RDL: o_cmd.rd_left    = i_sts.has_left;
            S_DN_RDR: begin
                o_cmd.rd_right   = i_sts.has_right;
                o_cmd.latch_left = 1'b1;
            end
            S_DN_CMP: o_cmd.swap_down = i_sts.dn_move;
            S_DONE:   o_cmd.emit      = 1'b1;
            default: ;
        endcase
        o_cmd.status = r_status;
    end

`include "assert_macros.svh"
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE, "done not followed by idle")
    `ASSERT_IMP(a_start_idle, i_clk, i_rst_n, o_cmd.latch_in, r_state == S_IDLE, "accept while busy")
    `ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, o_cmd.latch_in, o_busy, "accepted word not worked")

endmodule

// File: rtl/core/imhq_dpath.sv
module imhq_dpath import imhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_done,
    output t_out_word o_out
);

    // heap store
    t_slot r_mem [Capacity];
    t_slot r_rd;

    logic [CountW-1:0] r_count;
    t_in_word          r_in;
    logic [CountW-1:0] r_idx;     // search index, also the upgrade write address
    logic [AddrW-1:0]  r_cur;
    t_slot             r_cur_d;   // entry being moved
    t_slot             r_left;
    t_slot             r_popped;
    logic              r_done;
    t_out_word         r_out;
    logic              r_pop_ld;  // last-slot read lands in r_rd this cycle

    logic [AddrW-1:0] w_par;
    logic [AddrW:0]   w_l, w_r;
    logic [AddrW-1:0] w_rd_addr;
    logic             w_we;
    logic [AddrW-1:0] w_wa;
    t_slot            w_wd;
    logic             w_left_win;
    logic             w_right_win;
    logic             w_has_left;
    logic             w_has_right;
    t_slot            w_best;
    logic [AddrW-1:0] w_best_a;
    logic [CountW-1:0] w_last;

    assign w_par = (r_cur - 1'b1) >> 1;
    assign w_l   = {r_cur, 1'b1};
    assign w_r   = {r_cur, 1'b0} + (AddrW+1)'(2);
    assign w_last = r_count - 1'b1;

    assign w_has_left  = ({1'b0, w_l} < (AddrW+2)'(r_count));
    assign w_has_right = ({1'b0, w_r} < (AddrW+2)'(r_count));

    // read port address
    always_comb begin
        w_rd_addr = r_idx[AddrW-1:0];
        if (i_cmd.rd_parent)     w_rd_addr = w_par;
        else if (i_cmd.rd_last)  w_rd_addr = w_last[AddrW-1:0];
        else if (i_cmd.rd_left)  w_rd_addr = w_l[AddrW-1:0];
        else if (i_cmd.rd_right) w_rd_addr = w_r[AddrW-1:0];
    end

    // sift-down choice: left tested first, right must strictly beat the better of left and moving entry
    always_comb begin
        w_left_win  = r_left.prio > r_cur_d.prio;
        w_best      = w_left_win ? r_left : r_cur_d;
        w_best_a    = w_l[AddrW-1:0];
        w_right_win = w_has_right && (r_rd.prio > w_best.prio);
        if (w_right_win) begin
            w_best   = r_rd;
            w_best_a = w_r[AddrW-1:0];
        end
    end

    // write port
    always_comb begin
        w_we = 1'b0;
        w_wa = r_cur;
        w_wd = r_cur_d;
        if (i_cmd.do_append) begin
            w_we = 1'b1;
            w_wa = r_count[AddrW-1:0];
            w_wd = '{key: r_in.key, prio: r_in.priority_req,
                     pay: r_in.payload[PayloadBits-1:0]};
        end else if (i_cmd.do_upgrade) begin
            w_we = 1'b1;
            w_wa = r_idx[AddrW-1:0];
            w_wd = '{key: r_rd.key, prio: r_in.priority_req, pay: r_rd.pay};
        end else if (i_cmd.swap_up) begin
            w_we = 1'b1;          // parent moves down into cursor slot
            w_wd = r_rd;
        end else if (i_cmd.swap_down) begin
            w_we = 1'b1;          // best child moves up
            w_wd = w_best;
        end else if (i_cmd.emit) begin
            w_we = 1'b1;          // settle moving entry in place
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_rd_addr];
    end

    // status
    always_comb begin
        o_sts.opcode      = r_in.opcode;
        o_sts.srch_end    = (r_idx >= r_count);
        o_sts.key_hit     = (r_rd.key == r_in.key);
        o_sts.prio_higher = (r_in.priority_req > r_rd.prio);
        o_sts.full        = (r_count >= CountW'(Capacity));
        o_sts.empty       = (r_count == '0);
        o_sts.pop_last    = (r_count == CountW'(1));
        o_sts.at_root     = (r_cur == '0);
        o_sts.up_move     = (r_cur_d.prio > r_rd.prio);
        o_sts.has_left    = w_has_left;
        o_sts.has_right   = w_has_right;
        o_sts.dn_move     = w_left_win || w_right_win;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_done   <= 1'b0;
            r_pop_ld <= 1'b0;
        end else begin
            r_done   <= i_cmd.emit;
            r_pop_ld <= i_cmd.rd_last;
            if (i_cmd.do_append) r_count <= r_count + 1'b1;
            if (i_cmd.pop_root)  r_count <= r_count - 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in     <= i_in;
            r_idx    <= '0;
            r_popped <= '0;
        end
        if (i_cmd.srch_next) r_idx <= r_idx + 1'b1;
        if (i_cmd.do_append) begin
            r_cur   <= r_count[AddrW-1:0];
            r_cur_d <= w_wd;
        end
        if (i_cmd.do_upgrade) begin
            r_cur   <= r_idx[AddrW-1:0];
            r_cur_d <= w_wd;
        end
        if (i_cmd.swap_up) r_cur <= w_par;
        if (i_cmd.pop_root) begin
            r_popped <= r_mem[0];
            r_cur    <= '0;
        end
        // moving entry for pop comes from the last-slot read
        if (r_pop_ld) r_cur_d <= r_rd;
        if (i_cmd.latch_left) r_left <= r_rd;
        if (i_cmd.swap_down) r_cur <= w_best_a;
        if (i_cmd.emit) begin
            r_out.status       <= i_cmd.status;
            r_out.out_key      <= r_popped.key;
            r_out.out_priority <= r_popped.prio;
            r_out.out_payload  <= 32'(r_popped.pay);
            r_out.entry_count  <= 9'(r_count);
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

`include "assert_macros.svh"
    `ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_count <= CountW'(Capacity), "count over capacity")
    `ASSERT_NEXT(a_emit_done, i_clk, i_rst_n, i_cmd.emit, r_done, "result not shown")
    `ASSERT_IMP(a_one_wr, i_clk, i_rst_n, 1'b1, $onehot0({i_cmd.do_append, i_cmd.do_upgrade, i_cmd.swap_up, i_cmd.swap_down}), "two writers")

endmodule

// File: rtl/core/indexed_max_heap_queue_core.sv
// Indexed max-heap job queue, 256 entries.
// Input channel: present a command word on i_in and raise start; it is
// taken at the rising edge where start is high and busy is low.
// Opcodes: enqueue (insert new key or raise an existing key's priority),
// pop (remove the root), any other opcode: contains (presence query).
// Output channel: one result word per command on o_out, kept until the next
// result and marked by o_done high for exactly one cycle; it must be taken then.
// Working: an enqueue or contains searches the occupied slots in turn,
// a read state and a compare state per stored key; each sift level then
// steps through a parent read and a compare (up) or reads of the left and
// right child and a compare (down). A pop skips the search and sifts
// down if entries remain. One command is worked at a time.
// Reset (synchronous, active low) empties the queue at once; slot
// contents need no clearing since only occupied slots are read.
module indexed_max_heap_queue_core import imhq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_in,
    output logic      busy,
    output logic      o_done,
    output t_out_word o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    imhq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    imhq_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_done  (o_done),
        .o_out   (o_out)
    );

endmodule

// File: bench/indexed_max_heap_queue_core_tb.sv
module indexed_max_heap_queue_core_tb;
    import imhq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_CONTAINS = 2'd2;
    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int unsigned SettleCycles = 600;
    localparam int unsigned IdleLimit    = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  i_in;
    logic      busy;
    logic      o_done;
    t_out_word o_out;

    indexed_max_heap_queue_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_in   (i_in),
        .busy   (busy),
        .o_done (o_done),
        .o_out  (o_out)
    );

    // shadow heap
    logic [63:0] hp_key [Capacity];
    logic [7:0]  hp_prio[Capacity];
    logic [31:0] hp_pay [Capacity];
    int unsigned hp_count;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int unsigned error_count;
    int unsigned stall_cycles;
    bit          sender_calm;
    bit          stimulus_done;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [63:0] k;
        logic [7:0]  p;
        logic [31:0] d;
        k = hp_key[a];  hp_key[a]  = hp_key[b];  hp_key[b]  = k;
        p = hp_prio[a]; hp_prio[a] = hp_prio[b]; hp_prio[b] = p;
        d = hp_pay[a];  hp_pay[a]  = hp_pay[b];  hp_pay[b]  = d;
    endfunction

    function automatic void rise_from(int unsigned at);
        int unsigned up;
        while (at > 0) begin
            up = (at - 1) / 2;
            if (hp_prio[at] <= hp_prio[up]) break;
            swap_slots(at, up);
            at = up;
        end
    endfunction

    function automatic void sink_from(int unsigned at);
        int unsigned best;
        forever begin
            best = at;
            if (2*at+1 < hp_count && hp_prio[2*at+1] > hp_prio[best]) best = 2*at+1;
            if (2*at+2 < hp_count && hp_prio[2*at+2] > hp_prio[best]) best = 2*at+2;
            if (best == at) break;
            swap_slots(at, best);
            at = best;
        end
    endfunction

    function automatic int unsigned slot_of(logic [63:0] key);
        for (int unsigned i = 0; i < hp_count; i++)
            if (hp_key[i] == key) return i;
        return hp_count;
    endfunction

    // work out the queue's answer to one command word
    function automatic t_out_word heap_answer(t_in_word w);
        t_out_word r;
        int unsigned pos;
        r = '0;
        if (w.opcode == OP_ENQ) begin
            pos = slot_of(w.key);
            if (pos < hp_count) begin
                if (w.priority_req > hp_prio[pos]) begin
                    hp_prio[pos] = w.priority_req;
                    rise_from(pos);
                    r.status = ST_UPGRADED;
                end else begin
                    r.status = ST_DUPLICATE;
                end
            end else if (hp_count >= Capacity) begin
                r.status = ST_FULL;
            end else begin
                hp_key[hp_count]  = w.key;
                hp_prio[hp_count] = w.priority_req;
                hp_pay[hp_count]  = w.payload;
                hp_count++;
                rise_from(hp_count - 1);
                r.status = ST_INSERTED;
            end
        end else if (w.opcode == OP_POP) begin
            if (hp_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.out_key      = hp_key[0];
                r.out_priority = hp_prio[0];
                r.out_payload  = hp_pay[0];
                hp_count--;
                if (hp_count > 0) begin
                    hp_key[0]  = hp_key[hp_count];
                    hp_prio[0] = hp_prio[hp_count];
                    hp_pay[0]  = hp_pay[hp_count];
                    sink_from(0);
                end
                r.status = ST_POPPED;
            end
        end else begin
            r.status = (slot_of(w.key) < hp_count) ? ST_FOUND : ST_ABSENT;
        end
        r.entry_count = hp_count[8:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // driver: the head of the queue is the word on i_in while start is high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // waiting
        end else begin
            if (start) begin
                expected_words.push_back(heap_answer(i_in));
                void'(pending_words.pop_front());
            end
            if (pending_words.size() > 0 &&
                (sender_calm || $urandom_range(99) >= 11)) begin
                i_in  <= pending_words[0];
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_done) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_out.status), 64'd0);
            end else begin
                want = expected_words.pop_front();
                if (o_out.status != want.status)
                    report_mismatch("status", 64'(o_out.status), 64'(want.status));
                if (o_out.out_key != want.out_key)
                    report_mismatch("out_key", o_out.out_key, want.out_key);
                if (o_out.out_priority != want.out_priority)
                    report_mismatch("out_priority", 64'(o_out.out_priority),
                                    64'(want.out_priority));
                if (o_out.out_payload != want.out_payload)
                    report_mismatch("out_payload", 64'(o_out.out_payload),
                                    64'(want.out_payload));
                if (o_out.entry_count != want.entry_count)
                    report_mismatch("entry_count", 64'(o_out.entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IdleLimit) begin
                $display("indexed_max_heap_queue_core regression: fail");
                $finish;
            end
        end
    end

    function automatic t_in_word make_word(logic [1:0] op, logic [63:0] key,
                                           logic [7:0] prio, logic [31:0] pay);
        t_in_word w;
        w.opcode = op; w.key = key; w.priority_req = prio; w.payload = pay;
        return w;
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // stimulus
    initial begin
        logic [63:0] pool[$];
        logic [63:0] k;
        int unsigned pick;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_in = '0;
        error_count = 0;
        stall_cycles = 0;
        sender_calm = 1'b0;
        stimulus_done = 1'b0;
        hp_count = 0;

        // directed: empty pop, extremes, duplicates, upgrades, spare opcode
        pending_words.push_back(make_word(OP_POP, '1, '1, '1));
        pending_words.push_back(make_word(OP_CONTAINS, '0, 8'd0, 32'd0));
        pending_words.push_back(make_word(OP_ENQ, '0, 8'd0, 32'h0));
        pending_words.push_back(make_word(OP_ENQ, '1, 8'hff, 32'hffff_ffff));
        pending_words.push_back(make_word(OP_ENQ, 64'h5555_aaaa_5555_aaaa, 8'h80, 32'h5a5a_a5a5));
        pending_words.push_back(make_word(OP_ENQ, 64'haaaa_5555_aaaa_5555, 8'h80, 32'ha5a5_5a5a));
        pending_words.push_back(make_word(OP_ENQ, '0, 8'd0, 32'h1234));
        pending_words.push_back(make_word(OP_ENQ, '0, 8'hff, 32'h0));
        pending_words.push_back(make_word(OP_ENQ, '1, 8'h10, 32'h0));
        pending_words.push_back(make_word(OP_CONTAINS, '1, 8'd0, 32'd0));
        pending_words.push_back(make_word(OP_SPARE, '0, 8'h33, 32'h77));
        pending_words.push_back(make_word(OP_SPARE, 64'h1, 8'h33, 32'h77));
        for (int i = 0; i < 6; i++)
            pending_words.push_back(make_word(OP_POP, rand_key(), 8'($urandom()),
                                              32'($urandom())));

        // fill to capacity, overflow with new and present keys, then drain past empty
        for (int i = 0; i < Capacity; i++)
            pending_words.push_back(make_word(OP_ENQ, 64'hc000_0000_0000_0000 | 64'(i),
                                              8'($urandom_range(255)), 32'($urandom())));
        pending_words.push_back(make_word(OP_ENQ, rand_key(), 8'hff, 32'($urandom())));
        pending_words.push_back(make_word(OP_ENQ, 64'hc000_0000_0000_0007, 8'hff, 32'd0));
        pending_words.push_back(make_word(OP_ENQ, 64'hc000_0000_0000_0009, 8'h00, 32'd0));
        for (int i = 0; i < Capacity + 2; i++)
            pending_words.push_back(make_word(OP_POP, rand_key(), 8'($urandom()),
                                              32'($urandom())));

        // random: half enqueue of fresh or reused keys, the rest pops and queries
        for (int i = 0; i < 215; i++) begin
            pick = $urandom_range(99);
            if (pool.size() > 0 && $urandom_range(1))
                k = pool[$urandom_range(pool.size() - 1)];
            else begin
                k = rand_key();
                pool.push_back(k);
                if (pool.size() > 64) void'(pool.pop_front());
            end
            if (pick < 50)
                pending_words.push_back(make_word(OP_ENQ, k, 8'($urandom()),
                                                  32'($urandom())));
            else if (pick < 80)
                pending_words.push_back(make_word(OP_POP, k, 8'($urandom()),
                                                  32'($urandom())));
            else
                pending_words.push_back(make_word($urandom_range(1) ? OP_CONTAINS : OP_SPARE,
                                                  k, 8'($urandom()), 32'($urandom())));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // calm stretch in the middle of the run
        wait (pending_words.size() < 500);
        sender_calm = 1'b1;
        wait (pending_words.size() < 300);
        sender_calm = 1'b0;

        wait (pending_words.size() == 0 && !start);
        wait (expected_words.size() == 0);
        repeat (SettleCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("indexed_max_heap_queue_core regression: pass");
        end else begin
            $display("indexed_max_heap_queue_core regression: fail");
        end
        $finish;
    end
endmodule
